[src/rls_pkg.sv]
// ----------------------------------------------------------------------------
// rls_pkg - shared definitions for the LED strip serializer
// Store geometry, input kinds, register indexes, command/status bundles.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int MAX_PIXELS = 256;
  localparam int PIX_IDX_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PCOUNT_W   = 9;
  localparam int CMP_W      = (PCOUNT_W > CNT_W) ? PCOUNT_W : CNT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_SHOW  = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T0_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T0_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T1_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_T1_LOW      = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic take;       // item transfer: latch products, update serializer, load result
    logic wr_en;      // store write this cycle
    logic wr_zero;    // write zeros (clear pass)
    logic wr_walk;    // address from walk counter, else latched index
    logic walk_clr;
    logic walk_inc;
    logic rd_en;      // fetch pixel at pixel_pos
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sending;
    logic idx_ok;         // pixel_index below active count
    logic active_zero;
    logic pix_advance;    // a tick now moves on to a new pixel
    logic walk_at_max;
    logic walk_at_active;
    logic out_blocked;    // result register full and stalled
  } ctl_sts_t;

  // x / 255 for x <= 255*255, exact
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

[src/rls_ctrl.sv]
// ----------------------------------------------------------------------------
// rls_ctrl - sequencing for the LED strip serializer
// Clear pass, item transfer, pixel write, fill walk and pixel fetch.
// ----------------------------------------------------------------------------
module rls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        kind,
  output logic              in_stall,
  input  rls_pkg::ctl_sts_t sts,
  output rls_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE) || sts.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.take     = accept;
    unique case (state)
      ST_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.wr_walk  = 1'b1;
        cmd.walk_inc = 1'b1;
        if (sts.walk_at_max) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            rls_pkg::KIND_WRITE: begin
              if (!sts.sending && sts.idx_ok) state_next = ST_WRITE;
            end
            rls_pkg::KIND_FILL: begin
              cmd.walk_clr = 1'b1;
              if (!sts.sending && !sts.active_zero) state_next = ST_FILL;
            end
            rls_pkg::KIND_SHOW: begin
              if (!sts.sending && !sts.active_zero) state_next = ST_LOAD;
            end
            default: begin
              if (sts.sending && sts.pix_advance) state_next = ST_LOAD;
            end
          endcase
        end
      end
      ST_WRITE: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FILL: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_walk  = 1'b1;
        cmd.walk_inc = 1'b1;
        if (sts.walk_at_active) state_next = ST_IDLE;
      end
      ST_LOAD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // store is never written mid-show
  a_no_write_while_sending: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && !cmd.wr_zero |-> !sts.sending)
    else $error("store write during show");

  // a fetch only happens for an active show
  a_load_only_sending: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> sts.sending)
    else $error("pixel fetch while idle");

  // a started show fetches pixel 0 next
  a_show_fetches: assert property (@(posedge clk) disable iff (rst)
    accept && kind == rls_pkg::KIND_SHOW && !sts.sending && !sts.active_zero
      |=> state == ST_LOAD)
    else $error("show did not fetch first pixel");

  // the pixel write state always hands back to idle
  a_write_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> state == ST_IDLE)
    else $error("pixel write longer than one cycle");

endmodule

[src/rls_datapath.sv]
// ----------------------------------------------------------------------------
// rls_datapath - registers, pixel store and bit serializer
// Scales colors at write time, holds the store, times the line bits.
// ----------------------------------------------------------------------------
module rls_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      pixel_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            line_level,
  output logic                            busy_res,
  output logic                            refused,
  input  rls_pkg::ctl_cmd_t               cmd,
  output rls_pkg::ctl_sts_t               sts
);

  // configuration
  logic [rls_pkg::PCOUNT_W-1:0] pixel_count;
  logic [7:0] brightness, t0_high, t0_low, t1_high, t1_low;
  logic [rls_pkg::CMP_W-1:0] active;

  // serializer state
  logic                           sending, sending_next;
  logic [rls_pkg::PIX_IDX_W-1:0]  pixel_pos, pixel_pos_next;
  logic [1:0]                     byte_pos, byte_pos_next;
  logic [2:0]                     bit_pos, bit_pos_next;
  logic                           high_phase, high_phase_next;
  logic [7:0]                     tick_count, tick_count_next;

  // write path
  logic [15:0] prod_r, prod_g, prod_b;
  logic [rls_pkg::PIX_IDX_W-1:0] wr_idx, walk, wr_addr;
  logic [23:0] wr_data;

  // store and current pixel
  logic [23:0] store [rls_pkg::MAX_PIXELS];
  logic [23:0] cur_px;

  logic [7:0] cur_byte, dur;
  logic       bit_val, level, tick_now, refuse_now;
  logic [8:0] cnt_inc;
  logic [rls_pkg::CMP_W-1:0] next_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
      brightness  <= 8'd255;
      t0_high     <= 8'd3;
      t0_low      <= 8'd9;
      t1_high     <= 8'd9;
      t1_low      <= 8'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rls_pkg::REG_PIXEL_COUNT: pixel_count <= cfg_data[rls_pkg::PCOUNT_W-1:0];
        rls_pkg::REG_BRIGHTNESS:  brightness  <= cfg_data[7:0];
        rls_pkg::REG_T0_HIGH:     t0_high     <= cfg_data[7:0];
        rls_pkg::REG_T0_LOW:      t0_low      <= cfg_data[7:0];
        rls_pkg::REG_T1_HIGH:     t1_high     <= cfg_data[7:0];
        rls_pkg::REG_T1_LOW:      t1_low      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // count saturates at the store size
  assign active = (rls_pkg::CMP_W'(pixel_count) > rls_pkg::CMP_W'(rls_pkg::MAX_PIXELS)) ?
                  rls_pkg::CMP_W'(rls_pkg::MAX_PIXELS) : rls_pkg::CMP_W'(pixel_count);

  // bit under transmission, byte order G R B
  always_comb begin
    case (byte_pos)
      2'd1:    cur_byte = cur_px[15:8];
      2'd2:    cur_byte = cur_px[7:0];
      default: cur_byte = cur_px[23:16];
    endcase
    bit_val = cur_byte[bit_pos];
    if (high_phase) dur = bit_val ? t1_high : t0_high;
    else            dur = bit_val ? t1_low  : t0_low;
    if (dur == 8'd0) dur = 8'd1;
    cnt_inc  = {1'b0, tick_count} + 9'd1;
    next_pos = rls_pkg::CMP_W'(pixel_pos) + rls_pkg::CMP_W'(1);
  end

  assign tick_now   = cmd.take && (kind == rls_pkg::KIND_TICK) && sending;
  assign refuse_now = (kind != rls_pkg::KIND_TICK) && sending;
  assign level      = tick_now && high_phase;

  always_comb begin
    sending_next    = sending;
    pixel_pos_next  = pixel_pos;
    byte_pos_next   = byte_pos;
    bit_pos_next    = bit_pos;
    high_phase_next = high_phase;
    tick_count_next = tick_count;
    if (cmd.take && (kind == rls_pkg::KIND_SHOW) && !sending && (active != '0)) begin
      sending_next    = 1'b1;
      pixel_pos_next  = '0;
      byte_pos_next   = 2'd0;
      bit_pos_next    = 3'd7;
      high_phase_next = 1'b1;
      tick_count_next = 8'd0;
    end else if (tick_now) begin
      if (cnt_inc < {1'b0, dur}) begin
        tick_count_next = cnt_inc[7:0];
      end else begin
        tick_count_next = 8'd0;
        if (high_phase) begin
          high_phase_next = 1'b0;
        end else begin
          high_phase_next = 1'b1;
          if (bit_pos != 3'd0) begin
            bit_pos_next = bit_pos - 3'd1;
          end else begin
            bit_pos_next = 3'd7;
            if (byte_pos < 2'd2) begin
              byte_pos_next = byte_pos + 2'd1;
            end else begin
              byte_pos_next = 2'd0;
              if (next_pos >= active) begin
                sending_next   = 1'b0;
                pixel_pos_next = '0;
              end else begin
                pixel_pos_next = pixel_pos + rls_pkg::PIX_IDX_W'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending    <= 1'b0;
      pixel_pos  <= '0;
      byte_pos   <= 2'd0;
      bit_pos    <= 3'd7;
      high_phase <= 1'b1;
      tick_count <= 8'd0;
      walk       <= '0;
      out_valid  <= 1'b0;
    end else begin
      sending    <= sending_next;
      pixel_pos  <= pixel_pos_next;
      byte_pos   <= byte_pos_next;
      bit_pos    <= bit_pos_next;
      high_phase <= high_phase_next;
      tick_count <= tick_count_next;
      if (cmd.walk_clr)      walk <= '0;
      else if (cmd.walk_inc) walk <= walk + rls_pkg::PIX_IDX_W'(1);
      if (cmd.take)          out_valid <= 1'b1;
      else if (!out_stall)   out_valid <= 1'b0;
    end
  end

  // result register and write operands
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      line_level <= level;
      busy_res   <= sending_next;
      refused    <= refuse_now;
      prod_r     <= 16'(red)   * 16'(brightness);
      prod_g     <= 16'(green) * 16'(brightness);
      prod_b     <= 16'(blue)  * 16'(brightness);
      wr_idx     <= rls_pkg::PIX_IDX_W'(pixel_index);
    end
  end

  assign wr_addr = cmd.wr_walk ? walk : wr_idx;
  assign wr_data = cmd.wr_zero ? 24'd0 :
                   {rls_pkg::div255(prod_g), rls_pkg::div255(prod_r),
                    rls_pkg::div255(prod_b)};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) store[wr_addr] <= wr_data;
    if (cmd.rd_en) cur_px <= store[pixel_pos];
  end

  always_comb begin
    sts.sending        = sending;
    sts.idx_ok         = rls_pkg::CMP_W'(pixel_index) < active;
    sts.active_zero    = (active == '0);
    sts.pix_advance    = !high_phase && !(cnt_inc < {1'b0, dur}) && (bit_pos == 3'd0)
                         && (byte_pos >= 2'd2) && (next_pos < active);
    sts.walk_at_max    = (walk == rls_pkg::PIX_IDX_W'(rls_pkg::MAX_PIXELS - 1));
    sts.walk_at_active = (rls_pkg::CMP_W'(walk) + rls_pkg::CMP_W'(1)) >= active;
    sts.out_blocked    = out_valid && out_stall;
  end

endmodule

[src/rgb_led_strip_serializer.sv]
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer - pixel store and one-wire LED strip encoder
// Top level: joins the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// After reset the block zeroes all MAX_PIXELS (256) entries of the pixel
// store and holds in_stall high meanwhile; register writes are taken as
// usual. Every item returns exactly one result. A tick, a show or a refused
// or out-of-range write ends at its transfer. An accepted pixel write does
// the color multiply at its transfer and the store write in the write state.
// A fill walks the active range on the single store write port. A show start,
// and any tick that moves the serializer on to the next pixel, adds the load
// state for the store read that fetches that pixel. So during a show a tick
// transfer is taken every cycle except right after each pixel boundary.
// Results sit in an output register, so a new item is taken while the
// previous result waits, provided the output is not stalled. Line timing
// uses the t0/t1 high/low registers in ticks (zero counts as one); colors
// are scaled by brightness/255 when written and stored as G-R-B.
// ----------------------------------------------------------------------------
module rgb_led_strip_serializer (
  input  logic                            clk,
  input  logic                            rst,
  // register write port
  input  logic                            cfg_write,
  input  logic [rls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data,
  // item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      pixel_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            line_level,
  output logic                            busy_res,
  output logic                            refused
);

  rls_pkg::ctl_cmd_t cmd;
  rls_pkg::ctl_sts_t sts;

  // sequencing: clear pass, transfer acceptance, write/fill/fetch steps
  rls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, multipliers, store, bit timing and result register
  rls_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_level  (line_level),
    .busy_res    (busy_res),
    .refused     (refused),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

[dv/rgb_led_strip_serializer_test.sv]
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer_test - self-checking bench for the LED strip encoder
// Runs pixel writes, fills, shows and line ticks through the block under
// random sender gaps and receiver stalls. A cycle-free model of the pixel
// store and the bit serializer predicts every result, and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_led_strip_serializer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // register slots past the end of the map; writes there must be dropped
  localparam logic [rls_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [rls_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int RAND_ITEMS    = 560;
  localparam int SHOW_TICK_CAP = 400;   // ticks spent on one show before moving on
  localparam int IDLE_LIMIT    = 3000;  // cycles with no transfer on either side
  localparam int END_SETTLE    = 20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } strip_item_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic refused;
  } strip_res_t;

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                           clk;
  logic                           rst         = 1'b1;
  logic                           cfg_write   = 1'b0;
  logic [rls_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [rls_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic [1:0]                     kind        = rls_pkg::KIND_TICK;
  logic [7:0]                     pixel_index = '0;
  logic [7:0]                     red         = '0;
  logic [7:0]                     green       = '0;
  logic [7:0]                     blue        = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic                           line_level;
  logic                           busy_res;
  logic                           refused;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  rgb_led_strip_serializer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_level  (line_level),
    .busy_res    (busy_res),
    .refused     (refused)
  );

  // --------------------------------------------------------------------------
  // strip model: register copies, pixel store and serializer position
  // --------------------------------------------------------------------------
  logic [23:0] grb_mem [rls_pkg::MAX_PIXELS];
  logic [8:0]  led_count;
  logic [7:0]  bright;
  logic [7:0]  t0_hi, t0_lo, t1_hi, t1_lo;
  logic        tx_on;       // show in progress
  logic        in_high;     // current bit is in its high phase
  logic [7:0]  led_pos;
  logic [1:0]  grb_sel;     // 0 green, 1 red, 2 blue
  logic [2:0]  bit_sel;
  logic [7:0]  phase_ticks;

  function automatic int unsigned active_leds();
    return (32'(led_count) > rls_pkg::MAX_PIXELS) ? rls_pkg::MAX_PIXELS : 32'(led_count);
  endfunction

  function automatic void rewind_tx();
    led_pos     = '0;
    grb_sel     = '0;
    bit_sel     = 3'd7;
    in_high     = 1'b1;
    phase_ticks = '0;
  endfunction

  function automatic void strip_reset();
    foreach (grb_mem[i]) grb_mem[i] = '0;
    led_count = '0;
    bright    = 8'd255;
    t0_hi     = 8'd3;
    t0_lo     = 8'd9;
    t1_hi     = 8'd9;
    t1_lo     = 8'd3;
    tx_on     = 1'b0;
    rewind_tx();
  endfunction

  function automatic void apply_reg(logic [rls_pkg::CFG_IDX_W-1:0] idx,
                                    logic [rls_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      rls_pkg::REG_PIXEL_COUNT: led_count = val[8:0];
      rls_pkg::REG_BRIGHTNESS:  bright    = val[7:0];
      rls_pkg::REG_T0_HIGH:     t0_hi     = val[7:0];
      rls_pkg::REG_T0_LOW:      t0_lo     = val[7:0];
      rls_pkg::REG_T1_HIGH:     t1_hi     = val[7:0];
      rls_pkg::REG_T1_LOW:      t1_lo     = val[7:0];
      default: ;
    endcase
  endfunction

  // brightness scaling, truncated
  function automatic logic [7:0] dim(logic [7:0] c);
    int unsigned p;
    p = (int'(c) * int'(bright)) / 255;
    return p[7:0];
  endfunction

  function automatic void store_grb(int unsigned idx, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b);
    if (idx < active_leds()) grb_mem[idx] = {dim(g), dim(r), dim(b)};
  endfunction

  // one line tick: returns the level driven during it, then advances
  function automatic logic line_tick();
    logic [23:0] px;
    logic [7:0]  cur_byte;
    logic        cur_bit;
    logic        lvl;
    int unsigned dur;
    if (!tx_on) return 1'b0;
    px = grb_mem[led_pos];
    case (grb_sel)
      2'd0:    cur_byte = px[23:16];
      2'd1:    cur_byte = px[15:8];
      default: cur_byte = px[7:0];
    endcase
    cur_bit = cur_byte[bit_sel];
    lvl     = in_high;
    if (in_high) dur = 32'(cur_bit ? t1_hi : t0_hi);
    else         dur = 32'(cur_bit ? t1_lo : t0_lo);
    if (dur == 0) dur = 1;
    // a period cut below the ticks already spent ends at this tick
    if (32'(phase_ticks) + 1 < dur) begin
      phase_ticks++;
      return lvl;
    end
    phase_ticks = '0;
    if (in_high) begin
      in_high = 1'b0;
      return lvl;
    end
    in_high = 1'b1;
    if (bit_sel != 3'd0) begin
      bit_sel--;
      return lvl;
    end
    bit_sel = 3'd7;
    if (grb_sel < 2'd2) begin
      grb_sel++;
      return lvl;
    end
    grb_sel = '0;
    if (32'(led_pos) + 1 >= active_leds()) begin
      tx_on = 1'b0;
      rewind_tx();
    end else begin
      led_pos++;
    end
    return lvl;
  endfunction

  function automatic strip_res_t serialize_item(strip_item_t it);
    strip_res_t  res;
    int unsigned nact;
    res  = '0;
    nact = active_leds();
    case (it.kind)
      rls_pkg::KIND_WRITE: begin
        if (tx_on) res.refused = 1'b1;
        else store_grb(32'(it.idx), it.r, it.g, it.b);
      end
      rls_pkg::KIND_FILL: begin
        if (tx_on) res.refused = 1'b1;
        else for (int unsigned i = 0; i < nact; i++) store_grb(i, it.r, it.g, it.b);
      end
      rls_pkg::KIND_SHOW: begin
        if (tx_on) begin
          res.refused = 1'b1;
        end else if (nact != 0) begin
          rewind_tx();
          tx_on = 1'b1;
        end
      end
      default: res.line = line_tick();
    endcase
    res.busy = tx_on;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // bookkeeping
  // --------------------------------------------------------------------------
  strip_item_t cmds_to_send [$];
  strip_res_t  line_results_due [$];
  int          sent_total  = 0;   // items queued for the driver
  int          taken_total = 0;   // input transfers seen
  int          fail_count  = 0;
  int          idle_cycles = 0;
  logic        in_took     = 1'b0;

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps, inputs change on falling edge
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    strip_item_t nxt;
    // move on only when the current item has transferred (or nothing is up)
    if (!rst && (!in_valid || in_took)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmds_to_send.size() != 0) begin
        nxt = cmds_to_send.pop_front();
        in_valid    <= 1'b1;
        kind        <= nxt.kind;
        pixel_index <= nxt.idx;
        red         <= nxt.r;
        green       <= nxt.g;
        blue        <= nxt.b;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          // one burst in four runs straight into the next
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern switches between modes over random runs of cycles
  // --------------------------------------------------------------------------
  int         stall_mode = 0;
  int         stall_run  = 0;
  logic [7:0] stall_phase = '0;

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(16, 96);
    end
    stall_run--;
    stall_phase++;
    case (stall_mode)
      0:       out_stall <= 1'b0;                          // always ready
      1:       out_stall <= ($urandom_range(0, 2) == 0);   // light random
      2:       out_stall <= stall_phase[2];                // regular on/off pattern
      default: out_stall <= ($urandom_range(0, 3) != 0);   // heavy random
    endcase
  end

  // --------------------------------------------------------------------------
  // monitor: predict on input transfer, check on result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    strip_item_t it;
    strip_res_t  want;
    logic        moved;
    in_took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        it.kind = kind;
        it.idx  = pixel_index;
        it.r    = red;
        it.g    = green;
        it.b    = blue;
        line_results_due.push_back(serialize_item(it));
        taken_total++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (line_results_due.size() == 0) begin
          note_fail($sformatf("result with nothing expected: line=%b busy=%b refused=%b",
                              line_level, busy_res, refused));
        end else begin
          want = line_results_due.pop_front();
          if (line_level !== want.line || busy_res !== want.busy ||
              refused !== want.refused)
            note_fail($sformatf({"result mismatch: line exp %b got %b, busy exp %b got %b,",
                                 " refused exp %b got %b"},
                                want.line, line_level, want.busy, busy_res,
                                want.refused, refused));
        end
      end
      // watchdog: nothing moving on either side for too long
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic set_reg(input logic [rls_pkg::CFG_IDX_W-1:0] idx,
                         input logic [rls_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send(input logic [1:0] k, input logic [7:0] idx, input logic [7:0] r,
                      input logic [7:0] g, input logic [7:0] b);
    strip_item_t it;
    it.kind = k;
    it.idx  = idx;
    it.r    = r;
    it.g    = g;
    it.b    = b;
    cmds_to_send.push_back(it);
    sent_total++;
  endtask

  task automatic send_rand(input logic [1:0] k, input logic [7:0] idx);
    send(k, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
  endtask

  // wait until every queued item has transferred and every result is back
  task automatic drain();
    while (taken_total != sent_total || line_results_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // mostly in the active range, now and then just past it or anywhere
  function automatic logic [7:0] pick_index();
    int unsigned nact;
    nact = active_leds();
    if (nact == 0 || $urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, (nact > 255) ? 255 : nact));
  endfunction

  // tick a running show in chunks, with write, fill and show commands mixed in
  task automatic run_show(input int cap);
    int spent;
    int chunk;
    spent = 0;
    while (tx_on && spent < cap) begin
      chunk = $urandom_range(8, 40);
      repeat (chunk) begin
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 2))
            0:       send_rand(rls_pkg::KIND_WRITE, pick_index());
            1:       send_rand(rls_pkg::KIND_FILL, 8'($urandom_range(0, 255)));
            default: send_rand(rls_pkg::KIND_SHOW, 8'($urandom_range(0, 255)));
          endcase
        end
        send_rand(rls_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
      end
      spent += chunk;
      drain();
    end
  endtask

  // small timing values keep shows short; a few long ones for range
  function automatic logic [rls_pkg::CFG_DATA_W-1:0] pick_timing();
    if ($urandom_range(0, 7) != 0) return 9'($urandom_range(0, 2));
    return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [rls_pkg::CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7: return 9'd1;
      8, 9, 10, 11:           return 9'd2;
      12:                     return 9'd0;
      13:                     return 9'd3;
      default:                return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int directed_end;
    strip_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: no LEDs in use, so show, write and fill all do nothing
    send_rand(rls_pkg::KIND_TICK, 8'd0);
    send_rand(rls_pkg::KIND_SHOW, 8'd0);
    send(rls_pkg::KIND_WRITE, 8'd0, 8'hff, 8'hff, 8'hff);
    send(rls_pkg::KIND_FILL, 8'd0, 8'hff, 8'hff, 8'hff);
    drain();

    // one LED, shortest timing with zero-length periods, writes off the map
    set_reg(rls_pkg::REG_PIXEL_COUNT, 9'd1);
    set_reg(rls_pkg::REG_T0_HIGH, 9'd0);
    set_reg(rls_pkg::REG_T0_LOW, 9'd1);
    set_reg(rls_pkg::REG_T1_HIGH, 9'd1);
    set_reg(rls_pkg::REG_T1_LOW, 9'd0);
    set_reg(REG_SPARE_6, 9'h1ff);
    set_reg(REG_SPARE_7, 9'h1ff);
    send(rls_pkg::KIND_WRITE, 8'd0, 8'hff, 8'h00, 8'ha5);
    send(rls_pkg::KIND_WRITE, 8'd1, 8'h00, 8'hff, 8'hff);     // at the count: dropped
    send(rls_pkg::KIND_WRITE, 8'd255, 8'hff, 8'hff, 8'hff);
    send_rand(rls_pkg::KIND_SHOW, 8'd0);
    drain();
    run_show(SHOW_TICK_CAP);

    // brightness extremes; upper data bit of an 8-bit register is dropped
    set_reg(rls_pkg::REG_BRIGHTNESS, 9'd0);
    send(rls_pkg::KIND_FILL, 8'd0, 8'hff, 8'hff, 8'hff);
    drain();
    set_reg(rls_pkg::REG_BRIGHTNESS, 9'h180);
    send(rls_pkg::KIND_WRITE, 8'd0, 8'hff, 8'hff, 8'hff);
    drain();
    set_reg(rls_pkg::REG_BRIGHTNESS, 9'd255);

    // count past the store saturates; fill walks all 256 entries
    set_reg(rls_pkg::REG_PIXEL_COUNT, 9'd511);
    send(rls_pkg::KIND_FILL, 8'd0, 8'h00, 8'hff, 8'h7f);
    drain();
    send(rls_pkg::KIND_WRITE, 8'd255, 8'hff, 8'h00, 8'hff);
    drain();

    // longest periods, then cut them and the count mid-show
    set_reg(rls_pkg::REG_T0_HIGH, 9'd255);
    set_reg(rls_pkg::REG_T0_LOW, 9'd255);
    set_reg(rls_pkg::REG_T1_HIGH, 9'd255);
    set_reg(rls_pkg::REG_T1_LOW, 9'd255);
    send_rand(rls_pkg::KIND_SHOW, 8'd0);
    repeat (30) send_rand(rls_pkg::KIND_TICK, 8'd0);
    drain();
    set_reg(rls_pkg::REG_T0_HIGH, 9'd1);
    set_reg(rls_pkg::REG_T1_HIGH, 9'd1);
    set_reg(rls_pkg::REG_T0_LOW, 9'd1);
    set_reg(rls_pkg::REG_T1_LOW, 9'd1);
    set_reg(rls_pkg::REG_PIXEL_COUNT, 9'd1);   // show ends after the LED in flight
    run_show(SHOW_TICK_CAP);
    directed_end = sent_total;

    // random phases: reconfigure, load pixels, show, tick it out
    while (sent_total < directed_end + RAND_ITEMS) begin
      set_reg(rls_pkg::REG_PIXEL_COUNT, pick_count());
      if ($urandom_range(0, 3) != 0)
        set_reg(rls_pkg::REG_BRIGHTNESS,
                {1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
      set_reg(rls_pkg::REG_T0_HIGH, pick_timing());
      set_reg(rls_pkg::REG_T0_LOW, pick_timing());
      set_reg(rls_pkg::REG_T1_HIGH, pick_timing());
      set_reg(rls_pkg::REG_T1_LOW, pick_timing());
      if ($urandom_range(0, 3) == 0)
        send_rand(rls_pkg::KIND_FILL, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) send_rand(rls_pkg::KIND_WRITE, pick_index());
      if ($urandom_range(0, 7) == 0)
        send_rand(rls_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0)
        send_rand(rls_pkg::KIND_SHOW, 8'($urandom_range(0, 255)));
      drain();
      run_show(SHOW_TICK_CAP);
    end

    drain();
    repeat (END_SETTLE) @(negedge clk);
    if (line_results_due.size() != 0)
      note_fail($sformatf("%0d results never arrived", line_results_due.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
src/rls_pkg.sv
src/rls_ctrl.sv
src/rls_datapath.sv
src/rgb_led_strip_serializer.sv
dv/rgb_led_strip_serializer_test.sv
